// ----- rtl/core/lscs_pkg.sv -----
`timescale 1ns / 1ps
package lscs_pkg;

  localparam int unsigned MAX_BEAMS_DEF = 2048;
  localparam int unsigned MAX_CONES_DEF = 32;

  localparam int unsigned RANGE_W    = 16;
  localparam int unsigned DIST_W     = 16;
  localparam int unsigned ANG_W      = 32;
  localparam int unsigned PT_W       = 18;
  localparam int unsigned OUT_W      = 17;
  localparam int unsigned SEG_W      = 12;
  localparam int unsigned CTOT_W     = 6;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [SEG_W-1:0] SEG_COUNT_MAX = 12'd4095;
  localparam logic [OUT_W-1:0] OUT_SAT       = 17'd65535;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_JOIN_DIST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONE_SEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COS_FIRST = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_FIRST = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COS_INCR  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SIN_INCR  = 3'd6;

  localparam logic [DIST_W-1:0] RST_MAX_RANGE = 16'd30000;
  localparam logic [DIST_W-1:0] RST_JOIN_DIST = 16'd200;
  localparam logic [DIST_W-1:0] RST_CONE_SEP  = 16'd1000;
  localparam logic [ANG_W-1:0]  RST_COS_FIRST = 32'h4000_0000;
  localparam logic [ANG_W-1:0]  RST_SIN_FIRST = 32'h0000_0000;
  localparam logic [ANG_W-1:0]  RST_COS_INCR  = 32'h4000_0000;
  localparam logic [ANG_W-1:0]  RST_SIN_INCR  = 32'h0000_0000;

  localparam logic KIND_CONE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [DIST_W-1:0] max_range;
    logic [DIST_W-1:0] join_dist;
    logic [DIST_W-1:0] cone_sep;
    logic [ANG_W-1:0]  cos_first;
    logic [ANG_W-1:0]  sin_first;
    logic [ANG_W-1:0]  cos_incr;
    logic [ANG_W-1:0]  sin_incr;
  } cfg_t;

  typedef struct packed {
    logic ld_cos;
    logic ld_sin;
  } ang_ld_t;

  // converted beam passed from front to back
  typedef struct packed {
    logic signed [PT_W-1:0] x;
    logic signed [PT_W-1:0] y;
    logic                   keep;
    logic                   scan_end;
  } pt_t;

  typedef struct packed {
    logic              kind;
    logic [OUT_W-1:0]  cone_x;
    logic [OUT_W-1:0]  cone_y;
    logic [SEG_W-1:0]  segment_total;
    logic [CTOT_W-1:0] cone_total;
    logic              cone_overflow;
    logic              last;
  } res_t;

endpackage

// ----- rtl/core/lscs_fifo.sv -----
`timescale 1ns / 1ps
module lscs_fifo #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_i,
  input  logic [W-1:0] wdata_i,
  output logic         full_o,
  input  logic         rd_i,
  output logic [W-1:0] rdata_o,
  output logic         empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;
  logic          do_wr, do_rd;

  assign full_o  = (cnt_q == (PW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) begin
        wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
      end
      if (do_rd) begin
        rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
      end
      cnt_q <= cnt_q + (PW+1)'(do_wr) - (PW+1)'(do_rd);
    end
  end

endmodule

// ----- rtl/core/lscs_div.sv -----
`timescale 1ns / 1ps
module lscs_div #(
  parameter int unsigned NUM_W = 30,
  parameter int unsigned DEN_W = 12
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0]        den_i,
  output logic                    done_o,
  output logic [NUM_W-1:0]        quo_o
);

  localparam int unsigned CW = $clog2(NUM_W + 1);

  logic             busy_q, done_q, neg_q;
  logic [CW-1:0]    cnt_q;
  logic [DEN_W-1:0] den_q, rem_q;
  logic [NUM_W-1:0] q_q;
  logic [DEN_W:0]   sh_c;
  logic             ge_c;

  // restoring division on the magnitude, one quotient bit a cycle
  assign sh_c   = {rem_q, q_q[NUM_W-1]};
  assign ge_c   = (sh_c >= {1'b0, den_q});
  assign done_o = done_q;
  assign quo_o  = neg_q ? (~q_q + 1'b1) : q_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      den_q  <= '0;
      rem_q  <= '0;
      q_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        neg_q  <= num_i[NUM_W-1];
        q_q    <= num_i[NUM_W-1] ? (~num_i + 1'b1) : num_i;
        den_q  <= den_i;
        rem_q  <= '0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        rem_q <= ge_c ? DEN_W'(sh_c - {1'b0, den_q}) : sh_c[DEN_W-1:0];
        q_q   <= {q_q[NUM_W-2:0], ge_c};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/core/lscs_front.sv -----
`timescale 1ns / 1ps
module lscs_front import lscs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  logic [RANGE_W-1:0] range_mm_i,
  input  logic               range_finite_i,
  input  logic               scan_end_i,
  output logic               busy_o,
  input  cfg_t               cfg_i,
  input  ang_ld_t            ang_ld_i,
  output pt_t                pt_o,
  output logic               pt_valid_o,
  input  logic               pt_full_i
);

  typedef enum logic [3:0] {
    F_IDLE, F_RC, F_RS, F_CC, F_SS, F_SC, F_CS, F_FIN, F_PUSH
  } fstate_e;

  fstate_e             state_q;
  logic [RANGE_W-1:0]  r_q;
  logic                keep_q, end_q;
  logic [ANG_W-1:0]    cos_q, sin_q, cos_n_q;
  logic [63:0]         acc_q, mul_q;
  logic [PT_W-1:0]     x_q, y_q;
  logic signed [32:0]  opa;
  logic signed [31:0]  opb;
  logic [63:0]         rnd_mul_c, rnd_acc_c, rnd_sum_c;

  // shared 33x32 multiplier, operands picked by step
  always_comb begin
    opa = '0;
    opb = '0;
    case (state_q)
      F_RC: begin opa = {17'b0, r_q};          opb = cos_q;          end
      F_RS: begin opa = {17'b0, r_q};          opb = sin_q;          end
      F_CC: begin opa = {cos_q[31], cos_q};    opb = cfg_i.cos_incr; end
      F_SS: begin opa = {sin_q[31], sin_q};    opb = cfg_i.sin_incr; end
      F_SC: begin opa = {sin_q[31], sin_q};    opb = cfg_i.cos_incr; end
      F_CS: begin opa = {cos_q[31], cos_q};    opb = cfg_i.sin_incr; end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= 64'(opa) * 64'(opb);
  end

  // round half up then drop 30 fraction bits
  assign rnd_mul_c = mul_q + 64'h2000_0000;
  assign rnd_acc_c = acc_q + 64'h2000_0000;
  assign rnd_sum_c = acc_q + mul_q + 64'h2000_0000;

  assign busy_o     = (state_q != F_IDLE);
  assign pt_valid_o = (state_q == F_PUSH);
  assign pt_o       = '{x: x_q, y: y_q, keep: keep_q, scan_end: end_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cos_q   <= RST_COS_FIRST;
      sin_q   <= RST_SIN_FIRST;
      cos_n_q <= '0;
      r_q     <= '0;
      keep_q  <= 1'b0;
      end_q   <= 1'b0;
      acc_q   <= '0;
      x_q     <= '0;
      y_q     <= '0;
    end else begin
      if (ang_ld_i.ld_cos) begin
        cos_q <= cfg_i.cos_first;
      end
      if (ang_ld_i.ld_sin) begin
        sin_q <= cfg_i.sin_first;
      end
      case (state_q)
        F_IDLE: begin
          if (push_i) begin
            r_q     <= range_mm_i;
            keep_q  <= range_finite_i && (range_mm_i < cfg_i.max_range);
            end_q   <= scan_end_i;
            state_q <= F_RC;
          end
        end
        F_RC: state_q <= F_RS;
        F_RS: begin
          x_q     <= rnd_mul_c[47:30];
          state_q <= F_CC;
        end
        F_CC: begin
          y_q     <= rnd_mul_c[47:30];
          state_q <= F_SS;
        end
        F_SS: begin
          acc_q   <= mul_q;
          state_q <= F_SC;
        end
        F_SC: begin
          acc_q   <= acc_q - mul_q;
          state_q <= F_CS;
        end
        F_CS: begin
          cos_n_q <= rnd_acc_c[61:30];
          acc_q   <= mul_q;
          state_q <= F_FIN;
        end
        F_FIN: begin
          if (end_q) begin
            cos_q <= cfg_i.cos_first;
            sin_q <= cfg_i.sin_first;
          end else begin
            cos_q <= cos_n_q;
            sin_q <= rnd_sum_c[61:30];
          end
          state_q <= F_PUSH;
        end
        F_PUSH: begin
          if (!pt_full_i) begin
            state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/lscs_back.sv -----
`timescale 1ns / 1ps
module lscs_back import lscs_pkg::*; #(
  parameter int unsigned MAX_BEAMS = MAX_BEAMS_DEF,
  parameter int unsigned MAX_CONES = MAX_CONES_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  pt_t  pt_i,
  input  logic pt_empty_i,
  output logic pt_pop_o,
  output res_t res_o,
  output logic res_push_o,
  input  logic res_full_i
);

  localparam int unsigned LEN_W = $clog2(MAX_BEAMS + 1);
  localparam int unsigned SUM_W = PT_W + 1 + $clog2(MAX_BEAMS);
  localparam int unsigned CNT_W = $clog2(MAX_CONES + 1);
  localparam int unsigned IDX_W = (MAX_CONES > 1) ? $clog2(MAX_CONES) : 1;
  localparam int unsigned SQ_W  = 2 * (PT_W + 1);

  typedef enum logic [4:0] {
    B_IDLE, B_CHK, B_J0, B_J1, B_J2, B_J3, B_CLOSE, B_DIV, B_S0, B_S1,
    B_RD, B_SA, B_SB, B_SC, B_STORE, B_EMIT, B_AFTER, B_ENDCHK, B_SUM
  } bstate_e;

  bstate_e                state_q;
  pt_t                    it_q;
  logic                   brk_q, open_q, ovf_q;
  logic signed [PT_W-1:0] prev_x_q, prev_y_q, cx_q, cy_q;
  logic signed [SUM_W-1:0] sum_x_q, sum_y_q;
  logic [LEN_W-1:0]       len_q;
  logic [SEG_W-1:0]       seg_q;
  logic [CNT_W-1:0]       cnt_q, j_q;
  logic [SQ_W-1:0]        lim_q, acc_q, mul_q;
  logic [2*PT_W-1:0]      mem_q [MAX_CONES];
  logic [2*PT_W-1:0]      rd_q;
  logic signed [PT_W-1:0] rd_x, rd_y;
  logic signed [PT_W:0]   opa;
  logic                   near_c, mem_we;
  logic                   div_start, div_done, div_done_x, div_done_y;
  logic [SUM_W-1:0]       qx, qy;

  assign rd_x = rd_q[2*PT_W-1:PT_W];
  assign rd_y = rd_q[PT_W-1:0];

  // squares of differences and of limits through one 19x19 multiplier
  always_comb begin
    case (state_q)
      B_J0:    opa = {3'b0, cfg_i.join_dist};
      B_J1:    opa = {it_q.x[PT_W-1], it_q.x} - {prev_x_q[PT_W-1], prev_x_q};
      B_J2:    opa = {it_q.y[PT_W-1], it_q.y} - {prev_y_q[PT_W-1], prev_y_q};
      B_S0:    opa = {3'b0, cfg_i.cone_sep};
      B_SA:    opa = {cx_q[PT_W-1], cx_q} - {rd_x[PT_W-1], rd_x};
      B_SB:    opa = {cy_q[PT_W-1], cy_q} - {rd_y[PT_W-1], rd_y};
      default: opa = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= SQ_W'(opa) * SQ_W'(opa);
  end

  assign near_c = ({1'b0, acc_q} + {1'b0, mul_q}) < {1'b0, lim_q};

  // cone store
  assign mem_we = (state_q == B_STORE) && (cnt_q < CNT_W'(MAX_CONES));
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cnt_q[IDX_W-1:0]] <= {cx_q, cy_q};
    end
    if ((state_q == B_RD) && (j_q != cnt_q)) begin
      rd_q <= mem_q[j_q[IDX_W-1:0]];
    end
  end

  assign div_start = (state_q == B_CLOSE) && open_q;
  assign div_done  = div_done_x && div_done_y;

  lscs_div #(.NUM_W(SUM_W), .DEN_W(LEN_W)) u_div_x (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(sum_x_q), .den_i(len_q),
    .done_o(div_done_x), .quo_o(qx)
  );

  lscs_div #(.NUM_W(SUM_W), .DEN_W(LEN_W)) u_div_y (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(sum_y_q), .den_i(len_q),
    .done_o(div_done_y), .quo_o(qy)
  );

  function automatic logic [OUT_W-1:0] sat_out(input logic signed [PT_W-1:0] v);
    logic [OUT_W-1:0] r;
    if (v > $signed({1'b0, OUT_SAT})) begin
      r = OUT_SAT;
    end else if (v < -$signed({1'b0, OUT_SAT})) begin
      r = ~OUT_SAT + 1'b1;
    end else begin
      r = v[OUT_W-1:0];
    end
    return r;
  endfunction

  assign pt_pop_o   = (state_q == B_IDLE) && !pt_empty_i;
  assign res_push_o = ((state_q == B_EMIT) || (state_q == B_SUM)) && !res_full_i;

  always_comb begin
    if (state_q == B_SUM) begin
      res_o = '{kind: KIND_SUMMARY, cone_x: '0, cone_y: '0, segment_total: seg_q,
                cone_total: CTOT_W'(cnt_q), cone_overflow: ovf_q, last: 1'b1};
    end else begin
      res_o = '{kind: KIND_CONE, cone_x: sat_out(cx_q), cone_y: sat_out(cy_q),
                segment_total: '0, cone_total: '0, cone_overflow: 1'b0,
                last: !it_q.scan_end};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= B_IDLE;
      it_q     <= '0;
      brk_q    <= 1'b0;
      open_q   <= 1'b0;
      ovf_q    <= 1'b0;
      prev_x_q <= '0;
      prev_y_q <= '0;
      cx_q     <= '0;
      cy_q     <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      len_q    <= '0;
      seg_q    <= '0;
      cnt_q    <= '0;
      j_q      <= '0;
      lim_q    <= '0;
      acc_q    <= '0;
    end else begin
      case (state_q)
        B_IDLE: begin
          if (!pt_empty_i) begin
            it_q    <= pt_i;
            state_q <= B_CHK;
          end
        end
        B_CHK: begin
          brk_q <= 1'b1;
          if (!it_q.keep) begin
            state_q <= B_ENDCHK;
          end else if (open_q && (len_q < LEN_W'(MAX_BEAMS))) begin
            state_q <= B_J0;
          end else begin
            state_q <= B_CLOSE;
          end
        end
        B_J0: state_q <= B_J1;
        B_J1: begin
          lim_q   <= mul_q;
          state_q <= B_J2;
        end
        B_J2: begin
          acc_q   <= mul_q;
          state_q <= B_J3;
        end
        B_J3: begin
          if (near_c) begin
            len_q    <= len_q + 1'b1;
            sum_x_q  <= sum_x_q + SUM_W'(it_q.x);
            sum_y_q  <= sum_y_q + SUM_W'(it_q.y);
            prev_x_q <= it_q.x;
            prev_y_q <= it_q.y;
            state_q  <= B_ENDCHK;
          end else begin
            state_q <= B_CLOSE;
          end
        end
        B_CLOSE: begin
          if (open_q) begin
            open_q  <= 1'b0;
            len_q   <= '0;
            sum_x_q <= '0;
            sum_y_q <= '0;
            if (seg_q != SEG_COUNT_MAX) begin
              seg_q <= seg_q + 1'b1;
            end
            state_q <= B_DIV;
          end else begin
            state_q <= B_AFTER;
          end
        end
        B_DIV: begin
          if (div_done) begin
            cx_q    <= qx[PT_W-1:0];
            cy_q    <= qy[PT_W-1:0];
            state_q <= B_S0;
          end
        end
        B_S0: state_q <= B_S1;
        B_S1: begin
          lim_q   <= mul_q;
          j_q     <= '0;
          state_q <= B_RD;
        end
        B_RD: state_q <= (j_q == cnt_q) ? B_STORE : B_SA;
        B_SA: state_q <= B_SB;
        B_SB: begin
          acc_q   <= mul_q;
          state_q <= B_SC;
        end
        B_SC: begin
          if (near_c) begin
            state_q <= B_AFTER;
          end else begin
            j_q     <= j_q + 1'b1;
            state_q <= B_RD;
          end
        end
        B_STORE: begin
          if (mem_we) begin
            cnt_q   <= cnt_q + 1'b1;
            state_q <= B_EMIT;
          end else begin
            ovf_q   <= 1'b1;
            state_q <= B_AFTER;
          end
        end
        B_EMIT: begin
          if (!res_full_i) begin
            state_q <= B_AFTER;
          end
        end
        B_AFTER: begin
          if (brk_q) begin
            open_q   <= 1'b1;
            len_q    <= LEN_W'(1);
            sum_x_q  <= SUM_W'(it_q.x);
            sum_y_q  <= SUM_W'(it_q.y);
            prev_x_q <= it_q.x;
            prev_y_q <= it_q.y;
            state_q  <= B_ENDCHK;
          end else begin
            state_q <= B_SUM;
          end
        end
        B_ENDCHK: begin
          if (it_q.scan_end) begin
            brk_q   <= 1'b0;
            state_q <= B_CLOSE;
          end else begin
            state_q <= B_IDLE;
          end
        end
        B_SUM: begin
          if (!res_full_i) begin
            prev_x_q <= '0;
            prev_y_q <= '0;
            open_q   <= 1'b0;
            sum_x_q  <= '0;
            sum_y_q  <= '0;
            len_q    <= '0;
            seg_q    <= '0;
            cnt_q    <= '0;
            ovf_q    <= 1'b0;
            state_q  <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_CONES))
    else $error("cone count beyond store depth");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> !res_full_i)
    else $error("result pushed into full queue");

  a_open_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (len_q != '0))
    else $error("open segment with no points");

  a_store_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("store write without count step");

endmodule

// ----- rtl/core/laser_scan_cone_segmenter_top.sv -----
`timescale 1ns / 1ps
// Channel   Dir  Handshake                 Words
// ingest    in   push / full               range_mm_i, range_finite_i, scan_end_i
// results   out  empty / pop               kind_o .. last_o
// config    in   cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// Front: six products per beam on one shared 33x32 multiplier; full until queued.
// Back: a kept beam that joins runs the join steps B_J0..B_J3; closing a segment
//   runs both dividers, then checks the centroid against each stored cone.
// Reset clears all control and scan state; the cone store is not cleared,
//   only entries below the cone count are read.
// A 2-word queue sits between front and back, a 4-word queue holds results;
//   a stalled result side holds the back, then the front, then full.
module laser_scan_cone_segmenter_top import lscs_pkg::*; #(
  parameter int unsigned MAX_BEAMS = MAX_BEAMS_DEF,
  parameter int unsigned MAX_CONES = MAX_CONES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push,
  output logic                  full,
  input  logic [RANGE_W-1:0]    range_mm_i,
  input  logic                  range_finite_i,
  input  logic                  scan_end_i,
  output logic                  empty,
  input  logic                  pop,
  output logic                  kind_o,
  output logic [OUT_W-1:0]      cone_x_o,
  output logic [OUT_W-1:0]      cone_y_o,
  output logic [SEG_W-1:0]      segment_total_o,
  output logic [CTOT_W-1:0]     cone_total_o,
  output logic                  cone_overflow_o,
  output logic                  last_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t    cfg_q;
  ang_ld_t ang_ld;
  pt_t     pt_w, pt_head;
  logic    pt_valid, pt_full, pt_empty, pt_pop;
  logic [$bits(pt_t)-1:0] pt_head_v;
  res_t    res_w, res_head;
  logic    res_push, res_full;
  logic [$bits(res_t)-1:0] res_head_v;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{max_range: RST_MAX_RANGE, join_dist: RST_JOIN_DIST,
                 cone_sep: RST_CONE_SEP, cos_first: RST_COS_FIRST,
                 sin_first: RST_SIN_FIRST, cos_incr: RST_COS_INCR,
                 sin_incr: RST_SIN_INCR};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MAX_RANGE: cfg_q.max_range <= cfg_data_i[DIST_W-1:0];
        REG_JOIN_DIST: cfg_q.join_dist <= cfg_data_i[DIST_W-1:0];
        REG_CONE_SEP:  cfg_q.cone_sep  <= cfg_data_i[DIST_W-1:0];
        REG_COS_FIRST: cfg_q.cos_first <= cfg_data_i;
        REG_SIN_FIRST: cfg_q.sin_first <= cfg_data_i;
        REG_COS_INCR:  cfg_q.cos_incr  <= cfg_data_i;
        REG_SIN_INCR:  cfg_q.sin_incr  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // writing a first angle restarts the beam angle in the cycle after the write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_ld <= '0;
    end else begin
      ang_ld.ld_cos <= cfg_we_i && (cfg_idx_i == REG_COS_FIRST);
      ang_ld.ld_sin <= cfg_we_i && (cfg_idx_i == REG_SIN_FIRST);
    end
  end

  lscs_front u_front (
    .clk_i, .rst_ni,
    .push_i(push), .range_mm_i, .range_finite_i, .scan_end_i,
    .busy_o(full), .cfg_i(cfg_q), .ang_ld_i(ang_ld),
    .pt_o(pt_w), .pt_valid_o(pt_valid), .pt_full_i(pt_full)
  );

  lscs_fifo #(.W($bits(pt_t)), .DEPTH(2)) u_pt_q (
    .clk_i, .rst_ni, .wr_i(pt_valid), .wdata_i(pt_w), .full_o(pt_full),
    .rd_i(pt_pop), .rdata_o(pt_head_v), .empty_o(pt_empty)
  );
  assign pt_head = pt_t'(pt_head_v);

  lscs_back #(.MAX_BEAMS(MAX_BEAMS), .MAX_CONES(MAX_CONES)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .pt_i(pt_head), .pt_empty_i(pt_empty),
    .pt_pop_o(pt_pop), .res_o(res_w), .res_push_o(res_push), .res_full_i(res_full)
  );

  lscs_fifo #(.W($bits(res_t)), .DEPTH(4)) u_res_q (
    .clk_i, .rst_ni, .wr_i(res_push), .wdata_i(res_w), .full_o(res_full),
    .rd_i(pop), .rdata_o(res_head_v), .empty_o(empty)
  );
  assign res_head = res_t'(res_head_v);

  assign kind_o          = res_head.kind;
  assign cone_x_o        = res_head.cone_x;
  assign cone_y_o        = res_head.cone_y;
  assign segment_total_o = res_head.segment_total;
  assign cone_total_o    = res_head.cone_total;
  assign cone_overflow_o = res_head.cone_overflow;
  assign last_o          = res_head.last;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
  import lscs_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  // front plus a full cone search and divide, with plenty of margin
  localparam int unsigned DRAIN_CYCLES = 1000;
  localparam int unsigned NCONES = MAX_CONES_DEF;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  push;
  logic                  full;
  logic [RANGE_W-1:0]    range_mm_i;
  logic                  range_finite_i;
  logic                  scan_end_i;
  logic                  empty;
  logic                  pop;
  logic                  kind_o;
  logic [OUT_W-1:0]      cone_x_o;
  logic [OUT_W-1:0]      cone_y_o;
  logic [SEG_W-1:0]      segment_total_o;
  logic [CTOT_W-1:0]     cone_total_o;
  logic                  cone_overflow_o;
  logic                  last_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  laser_scan_cone_segmenter_top dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Segmenter model: configuration copy and per-scan state
  // ---------------------------------------------------------------------------
  int unsigned lim_range, join_mm, sep_mm;
  logic [31:0] cos0, sin0, cosd, sind;
  logic [31:0] bcos, bsin;
  longint      px, py, sx, sy;
  bit          seg_on;
  int unsigned slen, nsegs, ncones;
  longint      store_x [NCONES];
  longint      store_y [NCONES];
  bit          ovf;

  res_t cone_q[$];   // words still owed by the block, oldest first
  res_t step_q[$];   // words caused by the beam being modelled

  int unsigned cycles, errors;
  bit          quiet;  // suppresses idling on both sides

  function automatic logic [63:0] qround(input logic [63:0] p);
    return (p + 64'h2000_0000) >> 30;
  endfunction

  function automatic longint sx18(input logic [63:0] b);
    logic signed [17:0] t;
    t = b[17:0];
    return longint'(t);
  endfunction

  function automatic logic [OUT_W-1:0] clamp17(input longint v);
    longint t;
    t = v;
    if (t > 65535) t = 65535;
    if (t < -65535) t = -65535;
    return t[OUT_W-1:0];
  endfunction

  task automatic emit_word(input logic k, input longint x, input longint y);
    res_t w;
    w = '0;
    w.kind = k;
    if (k == KIND_CONE) begin
      w.cone_x = clamp17(x);
      w.cone_y = clamp17(y);
    end else begin
      w.segment_total = nsegs[SEG_W-1:0];
      w.cone_total    = ncones[CTOT_W-1:0];
      w.cone_overflow = ovf;
    end
    step_q = {step_q, w};
  endtask

  task automatic close_seg();
    longint cx, cy, dx, dy, sep2;
    bit     near_one;
    if (!seg_on || slen == 0) begin
      seg_on = 1'b0;
      return;
    end
    cx = sx / longint'(slen);
    cy = sy / longint'(slen);
    if (nsegs < SEG_COUNT_MAX) nsegs++;
    seg_on = 1'b0;
    slen = 0;
    sx = 0;
    sy = 0;
    sep2 = longint'(sep_mm) * longint'(sep_mm);
    near_one = 1'b0;
    for (int j = 0; j < ncones; j++) begin
      dx = cx - store_x[j];
      dy = cy - store_y[j];
      if (dx * dx + dy * dy < sep2) near_one = 1'b1;
    end
    if (near_one) return;
    if (ncones < NCONES) begin
      store_x[ncones] = cx;
      store_y[ncones] = cy;
      ncones++;
      emit_word(KIND_CONE, cx, cy);
    end else begin
      ovf = 1'b1;
    end
  endtask

  task automatic clear_scan();
    bcos = cos0;
    bsin = sin0;
    px = 0;
    py = 0;
    seg_on = 1'b0;
    sx = 0;
    sy = 0;
    slen = 0;
    nsegs = 0;
    ncones = 0;
    ovf = 1'b0;
  endtask

  // advance the model by one accepted beam, queueing the words it causes
  task automatic model_beam(input logic [15:0] r, input bit fin, input bit eos);
    longint c, s, ci, si, x, y, dx, dy;
    logic [63:0] t;
    c  = longint'($signed(bcos));
    s  = longint'($signed(bsin));
    ci = longint'($signed(cosd));
    si = longint'($signed(sind));
    step_q.delete();
    if (fin && r < lim_range) begin
      x = sx18(qround(longint'(r) * c));
      y = sx18(qround(longint'(r) * s));
      dx = x - px;
      dy = y - py;
      if (seg_on && dx * dx + dy * dy < longint'(join_mm) * longint'(join_mm) &&
          slen < MAX_BEAMS_DEF) begin
        slen++;
        sx += x;
        sy += y;
      end else begin
        close_seg();
        seg_on = 1'b1;
        slen = 1;
        sx = x;
        sy = y;
      end
      px = x;
      py = y;
    end
    t = qround(c * ci - s * si);
    bcos = t[31:0];
    t = qround(s * ci + c * si);
    bsin = t[31:0];
    if (eos) begin
      close_seg();
      emit_word(KIND_SUMMARY, 0, 0);
      clear_scan();
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].last = 1'b1;
    cone_q = {cone_q, step_q};
  endtask

  // ---------------------------------------------------------------------------
  // Driving
  // ---------------------------------------------------------------------------
  function automatic bit idles();
    return !quiet && ($urandom_range(0, 99) < 12);
  endfunction

  task automatic send_beam(input logic [15:0] r, input bit fin, input bit eos);
    while (idles()) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push           <= 1'b1;
    range_mm_i     <= r;
    range_finite_i <= fin;
    scan_end_i     <= eos;
    do @(posedge clk_i); while (full);
    model_beam(r, fin, eos);
  endtask

  // block idle: nothing owed, and time for beams that cause no word
  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (cone_q.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    case (idx)
      REG_MAX_RANGE: lim_range = 32'(val[15:0]);
      REG_JOIN_DIST: join_mm = 32'(val[15:0]);
      REG_CONE_SEP:  sep_mm = 32'(val[15:0]);
      REG_COS_FIRST: begin cos0 = val; bcos = val; end
      REG_SIN_FIRST: begin sin0 = val; bsin = val; end
      REG_COS_INCR:  cosd = val;
      REG_SIN_INCR:  sind = val;
      default: ;
    endcase
  endtask

  task automatic cfg_all(input logic [15:0] mr, input logic [15:0] jd,
                         input logic [15:0] cs, input logic [31:0] c0,
                         input logic [31:0] s0, input logic [31:0] ci,
                         input logic [31:0] si);
    cfg_write(REG_MAX_RANGE, {16'd0, mr});
    cfg_write(REG_JOIN_DIST, {16'd0, jd});
    cfg_write(REG_CONE_SEP, {16'd0, cs});
    cfg_write(REG_COS_FIRST, c0);
    cfg_write(REG_SIN_FIRST, s0);
    cfg_write(REG_COS_INCR, ci);
    cfg_write(REG_SIN_INCR, si);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: pop at random, check each word against the oldest owed
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    res_t got, want;
    if (rst_ni) begin
      if (pop && !empty) begin
        got = '{kind_o, cone_x_o, cone_y_o, segment_total_o, cone_total_o,
                cone_overflow_o, last_o};
        if (cone_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected word: kind %0b x %0d y %0d segs %0d cones %0d",
                     got.kind, $signed(got.cone_x), $signed(got.cone_y),
                     got.segment_total, got.cone_total);
        end else begin
          want = cone_q.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"mismatch: kind %0b/%0b x %0d/%0d y %0d/%0d segs %0d/%0d ",
                        "cones %0d/%0d ovf %0b/%0b last %0b/%0b (exp/got)"},
                       want.kind, got.kind, $signed(want.cone_x), $signed(got.cone_x),
                       $signed(want.cone_y), $signed(got.cone_y), want.segment_total,
                       got.segment_total, want.cone_total, got.cone_total,
                       want.cone_overflow, got.cone_overflow, want.last, got.last);
          end
        end
      end
      pop <= !idles();
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("** laser_scan_cone_segmenter_top: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed beams at reset settings (x = range, y = 0). Summaries with
  // typed counts are written out in full; cone words come from the model.
  // ---------------------------------------------------------------------------
  typedef struct {
    int unsigned rng;
    bit          fin;
    bit          eos;
    bit          typed;
    int unsigned segs;
    int unsigned cones;
  } beam_row_t;

  localparam int NROWS = 14;
  beam_row_t rows [NROWS] = '{
    '{0,     0, 1, 1, 0, 0},  // empty scan straight after reset
    '{1000,  1, 0, 0, 0, 0},
    '{1100,  1, 0, 0, 0, 0},  // joins
    '{5000,  1, 0, 0, 0, 0},  // jump: first cone out, break point opens next
    '{65535, 1, 1, 1, 2, 2},  // out of range, only closes the scan
    '{2000,  1, 0, 0, 0, 0},
    '{2500,  1, 0, 0, 0, 0},
    '{2100,  1, 1, 1, 3, 1},  // both later centroids too close to the first
    '{29999, 1, 1, 1, 1, 1},  // just inside the range limit
    '{30000, 1, 1, 1, 0, 0},  // at the range limit
    '{65535, 0, 1, 1, 0, 0},  // non-finite
    '{0,     1, 0, 0, 0, 0},  // zero range is a real point
    '{3000,  0, 0, 0, 0, 0},  // non-finite does not break the segment
    '{100,   1, 1, 1, 1, 1}
  };

  task automatic run_scan(input int npts, input bit close_it);
    int unsigned base, r;
    bit          fin;
    base = $urandom_range(0, 65535);
    for (int i = 0; i < npts; i++) begin
      fin = 1'b1;
      case ($urandom_range(0, 9))
        0: r = $urandom_range(0, 65535);               // jump anywhere
        1: begin r = $urandom_range(0, 65535); fin = 1'b0; end
        2: r = (lim_range > 0) ? $urandom_range(lim_range, 65535) : 0;
        3: begin base = $urandom_range(0, 65535); r = base; end
        default: begin
          r = base + $urandom_range(0, 120);
          if (r > 65535) r = 65535;
          base = r;
        end
      endcase
      send_beam(r[15:0], fin, close_it && (i == npts - 1));
    end
  endtask

  function automatic logic [31:0] pick_ang(input bit incr);
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom();
      default: return incr ? 32'h3ff0_0000 + $urandom_range(0, 32'h1f_ffff)
                           : $urandom_range(0, 32'h7fff_ffff);
    endcase
  endfunction

  function automatic logic [15:0] pick_dist(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(0, 3))
      0: return 16'd0;
      1: return 16'hffff;
      default: return 16'($urandom_range(lo, hi));
    endcase
  endfunction

  initial begin
    push = 1'b0;
    pop = 1'b0;
    range_mm_i = '0;
    range_finite_i = 1'b0;
    scan_end_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    rst_ni = 1'b0;
    cycles = 0;
    errors = 0;
    quiet = 1'b0;
    lim_range = 32'(RST_MAX_RANGE);
    join_mm = 32'(RST_JOIN_DIST);
    sep_mm = 32'(RST_CONE_SEP);
    cos0 = RST_COS_FIRST;
    sin0 = RST_SIN_FIRST;
    cosd = RST_COS_INCR;
    sind = RST_SIN_INCR;
    clear_scan();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      send_beam(rows[i].rng[15:0], rows[i].fin, rows[i].eos);
      if (rows[i].typed)
        cone_q[cone_q.size()-1] = '{KIND_SUMMARY, '0, '0, rows[i].segs[SEG_W-1:0],
                                    rows[i].cones[CTOT_W-1:0], 1'b0, 1'b1};
    end
    settle();

    // full store: every beam its own segment, nothing counts as near
    quiet = 1'b1;
    cfg_all(16'hffff, 16'd0, 16'd0, RST_COS_FIRST, RST_SIN_FIRST,
            RST_COS_INCR, RST_SIN_INCR);
    for (int i = 0; i < 40; i++) send_beam(16'(i * 1500 + 7), 1'b1, i == 39);
    settle();
    quiet = 1'b0;

    // random phases; the first two sit at the register extremes
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0)
        cfg_all(16'hffff, 16'hffff, 16'hffff, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h7fff_ffff, 32'h7fff_ffff);
      else if (ph == 1)
        cfg_all(16'd0, 16'd0, 16'd0, 32'h8000_0000, 32'h8000_0000,
                32'h8000_0000, 32'h8000_0000);
      else
        cfg_all(($urandom_range(0, 3) == 0) ? 16'hffff : pick_dist(20000, 65535),
                pick_dist(50, 400), pick_dist(100, 3000), pick_ang(1'b0),
                pick_ang(1'b0), pick_ang(1'b1), $urandom_range(0, 32'hf_ffff));
      quiet = (ph == 4);
      for (int s = 0; s < 3; s++)
        run_scan($urandom_range(3, 9), (s < 2) || ($urandom_range(0, 1) == 1));
      settle();
    end

    quiet = 1'b0;
    if (errors == 0) begin
      $display("** laser_scan_cone_segmenter_top: PASSED **");
    end else begin
      $display("** laser_scan_cone_segmenter_top: FAILED **");
    end
    $finish;
  end

endmodule
